@@ rtl/key_value_line_tokenizer_assert.svh @@
// Assertion macros used by the tokenizer back end (kvt_back).
`ifndef KEY_VALUE_LINE_TOKENIZER_ASSERT_SVH
`define KEY_VALUE_LINE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define KVT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed (same cycle)");

// Next-cycle implication, checked on every rising edge out of reset.
`define KVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed (next cycle)");

`endif

@@ rtl/kvt_pkg.sv @@
// Types, character codes and command format shared by the tokenizer modules.
package kvt_pkg;

    localparam int PENDING_DEPTH_DEF = 15;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_QUAL  = 2'd1,
        KIND_VALUE = 2'd2,
        KIND_END   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_EMIT  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // One classified item handed from the front to the back.
    typedef struct packed {
        op_t        op;
        kind_t      kind;
        logic [7:0] ch;
        logic       flush;  // emit held qualifier whitespace first
        logic       space;  // emit one collapsed value space first
    } cmd_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

endpackage

@@ rtl/kvt_queue.sv @@
// Short command queue between the classifying front and the emitting back.
module kvt_queue
    import kvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.avail = (count_reg != '0);

endmodule

@@ rtl/kvt_front.sv @@
// Line parser: accepts characters, tracks the field phase and queues commands.
module kvt_front
    import kvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] character
    input  logic       s_tlast,   // line_end
    input  q_status_t  q_status,
    output logic       push,
    output cmd_t       push_cmd
);

    typedef enum logic [7:0] {
        PH_BEFORE_NAME  = 8'b0000_0001,
        PH_NAME         = 8'b0000_0010,
        PH_AFTER_NAME   = 8'b0000_0100,
        PH_QUAL         = 8'b0000_1000,
        PH_DONE         = 8'b0001_0000,
        PH_BEFORE_VALUE = 8'b0010_0000,
        PH_VALUE        = 8'b0100_0000,
        PH_VALUE_WS     = 8'b1000_0000
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   started_reg, started_next;
    logic   ignored_reg, ignored_next;

    logic   accept;
    logic   ws;
    logic   is_eq;
    logic   ign;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign ws       = (s_tdata == CHAR_SPACE) || (s_tdata == CHAR_TAB);
    assign is_eq    = (s_tdata == CHAR_EQ);
    assign ign      = ignored_reg || (!started_reg && ((s_tdata == CHAR_SLASH) ||
                      (s_tdata == CHAR_HASH) || (s_tdata == CHAR_PCT)));

    always_comb
    begin
        phase_next     = phase_reg;
        started_next   = started_reg;
        ignored_next   = ignored_reg;
        push           = 1'b0;
        push_cmd.op    = OP_EMIT;
        push_cmd.kind  = KIND_NAME;
        push_cmd.ch    = s_tdata;
        push_cmd.flush = 1'b0;
        push_cmd.space = 1'b0;
        if (accept)
        begin
            if (s_tlast)
            begin
                push           = !ignored_reg;
                push_cmd.kind  = KIND_END;
                push_cmd.ch    = CHAR_NUL;
                push_cmd.flush = (phase_reg == PH_QUAL);
                phase_next     = PH_BEFORE_NAME;
                started_next   = 1'b0;
                ignored_next   = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                ignored_next = ign;
                if (!ign)
                begin
                    unique case (phase_reg)
                        PH_BEFORE_NAME:
                        begin
                            if (!ws)
                            begin
                                push       = 1'b1;
                                phase_next = PH_NAME;
                            end
                        end
                        PH_NAME:
                        begin
                            if (ws)
                                phase_next = PH_AFTER_NAME;
                            else
                                push = 1'b1;
                        end
                        PH_AFTER_NAME:
                        begin
                            if (is_eq)
                                phase_next = PH_BEFORE_VALUE;
                            else if (!ws)
                            begin
                                push          = 1'b1;
                                push_cmd.kind = KIND_QUAL;
                                phase_next    = PH_QUAL;
                            end
                        end
                        PH_QUAL:
                        begin
                            push          = 1'b1;
                            push_cmd.kind = KIND_QUAL;
                            if (is_eq)
                            begin
                                push_cmd.op = OP_CLEAR;
                                phase_next  = PH_BEFORE_VALUE;
                            end
                            else if (ws)
                                push_cmd.op = OP_PUSH;
                            else
                                push_cmd.flush = 1'b1;
                        end
                        PH_BEFORE_VALUE:
                        begin
                            if (!ws)
                            begin
                                push          = 1'b1;
                                push_cmd.kind = KIND_VALUE;
                                phase_next    = PH_VALUE;
                            end
                        end
                        PH_VALUE:
                        begin
                            push_cmd.kind = KIND_VALUE;
                            if (ws)
                                phase_next = PH_VALUE_WS;
                            else
                                push = 1'b1;
                        end
                        PH_VALUE_WS:
                        begin
                            push_cmd.kind = KIND_VALUE;
                            if (s_tdata == CHAR_PCT)
                                phase_next = PH_DONE;
                            else if (!ws)
                            begin
                                push           = 1'b1;
                                push_cmd.space = 1'b1;
                                phase_next     = PH_VALUE;
                            end
                        end
                        PH_DONE:
                        begin
                            push = 1'b0;
                        end
                        default:
                        begin
                            phase_next = PH_BEFORE_NAME;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_BEFORE_NAME;
            started_reg <= 1'b0;
            ignored_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            started_reg <= started_next;
            ignored_reg <= ignored_next;
        end
    end

endmodule

@@ rtl/kvt_back.sv @@
// Result sequencer: holds qualifier whitespace and emits result items.
`include "key_value_line_tokenizer_assert.svh"

module kvt_back
    import kvt_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic [1:0] m_tuser,   // [1:0] field_kind
    output logic       m_tlast    // last
);

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    logic             pend_tab_reg [PENDING_DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             space_done_reg, space_done_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg;
    kind_t            out_kind_reg;
    logic             out_last_reg;

    logic             out_free;
    logic             load;
    logic             do_flush;
    logic             do_space;
    logic             final_step;
    logic             store_ws;
    logic [7:0]       res_char;
    kind_t            res_kind;
    logic             res_last;

    assign out_free = !out_valid_reg || m_tready;
    assign do_flush = head.flush && (idx_reg < cnt_reg);
    assign do_space = head.space && !space_done_reg;

    always_comb
    begin
        load            = 1'b0;
        pop             = 1'b0;
        final_step      = 1'b0;
        store_ws        = 1'b0;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        space_done_next = space_done_reg;
        res_char        = head.ch;
        res_kind        = head.kind;
        res_last        = 1'b1;
        if (q_status.avail)
        begin
            unique case (head.op)
                OP_EMIT:
                begin
                    if (out_free)
                    begin
                        load = 1'b1;
                        priority if (do_flush)
                        begin
                            // held whitespace goes out in arrival order
                            res_kind = KIND_QUAL;
                            res_char = pend_tab_reg[idx_reg[IDX_W-1:0]] ? CHAR_TAB : CHAR_SPACE;
                            res_last = 1'b0;
                            idx_next = idx_reg + CNT_W'(1);
                        end
                        else if (do_space)
                        begin
                            res_kind        = KIND_VALUE;
                            res_char        = CHAR_SPACE;
                            res_last        = 1'b0;
                            space_done_next = 1'b1;
                        end
                        else
                        begin
                            final_step      = 1'b1;
                            pop             = 1'b1;
                            idx_next        = '0;
                            space_done_next = 1'b0;
                            if (head.flush || head.kind == KIND_END)
                                cnt_next = '0;
                        end
                    end
                end
                OP_PUSH:
                begin
                    pop = 1'b1;
                    // drop whitespace once the store is full
                    if (cnt_reg < CNT_W'(PENDING_DEPTH))
                    begin
                        store_ws = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                OP_CLEAR:
                begin
                    pop      = 1'b1;
                    cnt_next = '0;
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
        out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            idx_reg        <= '0;
            space_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            space_done_reg <= space_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_ws)
            pend_tab_reg[cnt_reg[IDX_W-1:0]] <= (head.ch == CHAR_TAB);
        if (load)
        begin
            out_char_reg <= res_char;
            out_kind_reg <= res_kind;
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `KVT_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(PENDING_DEPTH))
    `KVT_ASSERT_IMPL(a_idx_bound, clk, rst_n, 1'b1, idx_reg <= cnt_reg)
    `KVT_ASSERT_NEXT(a_end_clears, clk, rst_n, final_step && head.kind == KIND_END, cnt_reg == '0)
    `KVT_ASSERT_IMPL(a_flush_qual, clk, rst_n, load && do_flush, res_kind == KIND_QUAL && !res_last)

endmodule

@@ rtl/key_value_line_tokenizer.sv @@
// A result item passes through the command queue, then the single output
// register of the result sequencer. Throughput: one input item per cycle
// while each yields at most one result and m_tready stays high; a qualifier
// flush or collapsed value space gives extra results. A 4-entry queue absorbs
// short bursts and holds s_tready low once full. Reset (rst_n low,
// asynchronous) empties the queue and output, and clears the parser state.
module key_value_line_tokenizer
    import kvt_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] character
    input  logic       s_tlast,   // line_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic [1:0] m_tuser,   // [1:0] field_kind
    output logic       m_tlast    // last
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head;

    kvt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    kvt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    kvt_back #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ dv/tb_top.sv @@
// Self-checking bench for the key/value line tokenizer: a directed table, then random text lines.
module tb_top;
    import kvt_pkg::*;

    localparam int HELD_MAX      = PENDING_DEPTH_DEF;
    localparam int PHASE_ITEMS   = 115;
    localparam int SETTLE_CYCLES = 16;
    localparam int TIMEOUT_TU    = 4_000_000;
    localparam logic BY_MODEL    = 1'b0;
    localparam logic BY_TABLE    = 1'b1;

    typedef enum logic [2:0] {
        LS_PRE_NAME,
        LS_NAME,
        LS_POST_NAME,
        LS_QUAL,
        LS_DONE,
        LS_PRE_VALUE,
        LS_VALUE,
        LS_VALUE_WS
    } line_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       last;
    } token_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } text_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
        logic       by_table;  // expected result typed into the row
        logic       one_res;   // typed row: one result (else none)
        kind_t      kind;
        logic [7:0] res_ch;
    } dir_row_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    int src_gap_pct   = 0;
    int snk_stall_pct = 0;
    int err_cnt       = 0;

    // tokenizer state as seen by the bench
    line_state_t ln_state;
    logic        ln_started;
    logic        ln_comment;
    logic [3:0]  held_cnt;
    logic        held_tab [HELD_MAX];

    token_t     step_out [$];
    logic       step_skipped;
    token_t     want_q [$];
    text_item_t line_q [$];
    dir_row_t   dir_tab [$];

    key_value_line_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    initial
    begin
        #(TIMEOUT_TU);
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        err_cnt++;
    endtask

    function void put(input kind_t k, input logic [7:0] c);
        token_t t;
        t.kind   = k;
        t.ch     = c;
        t.last   = 1'b0;
        step_out = {step_out, t};
    endfunction

    function void queue_want(input token_t t);
        want_q = {want_q, t};
    endfunction

    function void add_text(input logic [7:0] c, input logic eol);
        text_item_t t;
        t.ch   = c;
        t.eol  = eol;
        line_q = {line_q, t};
    endfunction

    function void flush_held();
        for (int i = 0; i < int'(held_cnt); i++)
            put(KIND_QUAL, held_tab[i] ? CHAR_TAB : CHAR_SPACE);
        held_cnt = '0;
    endfunction

    function void clear_line();
        ln_state   = LS_PRE_NAME;
        ln_started = 1'b0;
        ln_comment = 1'b0;
        held_cnt   = '0;
    endfunction

    // Work out the result items caused by one accepted input item.
    function void tokenize(input logic [7:0] c, input logic eol);
        logic ws;
        ws = (c == CHAR_SPACE) || (c == CHAR_TAB);
        step_out.delete();
        step_skipped = ln_comment;
        if (eol)
        begin
            if (!ln_comment)
            begin
                if (ln_state == LS_QUAL)
                    flush_held();
                put(KIND_END, CHAR_NUL);
            end
            clear_line();
        end
        else
        begin
            if (!ln_started)
            begin
                ln_started = 1'b1;
                if (c == CHAR_SLASH || c == CHAR_HASH || c == CHAR_PCT)
                    ln_comment = 1'b1;
            end
            step_skipped = ln_comment;
            if (!ln_comment)
            begin
                case (ln_state)
                    LS_PRE_NAME:
                        if (!ws)
                        begin
                            put(KIND_NAME, c);
                            ln_state = LS_NAME;
                        end
                    LS_NAME:
                        if (ws)
                            ln_state = LS_POST_NAME;
                        else
                            put(KIND_NAME, c);
                    LS_POST_NAME:
                        if (c == CHAR_EQ)
                            ln_state = LS_PRE_VALUE;
                        else if (!ws)
                        begin
                            put(KIND_QUAL, c);
                            ln_state = LS_QUAL;
                        end
                    LS_QUAL:
                        if (c == CHAR_EQ)
                        begin
                            // drop trailing qualifier whitespace
                            held_cnt = '0;
                            ln_state = LS_PRE_VALUE;
                        end
                        else if (ws)
                        begin
                            if (int'(held_cnt) < HELD_MAX)
                            begin
                                held_tab[held_cnt] = (c == CHAR_TAB);
                                held_cnt++;
                            end
                        end
                        else
                        begin
                            flush_held();
                            put(KIND_QUAL, c);
                        end
                    LS_PRE_VALUE:
                        if (!ws)
                        begin
                            put(KIND_VALUE, c);
                            ln_state = LS_VALUE;
                        end
                    LS_VALUE:
                        if (ws)
                            ln_state = LS_VALUE_WS;
                        else
                            put(KIND_VALUE, c);
                    LS_VALUE_WS:
                        if (c == CHAR_PCT)
                            ln_state = LS_DONE;
                        else if (!ws)
                        begin
                            put(KIND_VALUE, CHAR_SPACE);
                            put(KIND_VALUE, c);
                            ln_state = LS_VALUE;
                        end
                    default:
                        ;
                endcase
            end
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    function logic [7:0] ws_char();
        return ($urandom_range(0, 1) != 0) ? CHAR_TAB : CHAR_SPACE;
    endfunction

    // Token byte: mostly printable, now and then any byte; never whitespace or '='.
    function logic [7:0] tok_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
            c = 8'($urandom_range(0, 255));
        else
            c = 8'($urandom_range(33, 126));
        if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_EQ)
            c = 8'h5F;
        return c;
    endfunction

    function void add_ws(input int n);
        repeat (n) add_text(ws_char(), 1'b0);
    endfunction

    function void add_tok(input int n);
        repeat (n) add_text(tok_char(), 1'b0);
    endfunction

    // Build one text line: mostly name [qualifier] = value, some comments, empty lines and noise.
    function void gen_line();
        int sel;
        sel = $urandom_range(0, 99);
        line_q.delete();
        if (sel < 6)
        begin
            case ($urandom_range(0, 2))
                0:       add_text(CHAR_SLASH, 1'b0);
                1:       add_text(CHAR_HASH, 1'b0);
                default: add_text(CHAR_PCT, 1'b0);
            endcase
            add_tok($urandom_range(0, 4));
            add_ws($urandom_range(0, 1));
        end
        else if (sel < 20)
        begin
            repeat ($urandom_range(1, 10))
                add_text(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (sel >= 25)
        begin
            add_ws(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            add_tok($urandom_range(1, 4));
            if ($urandom_range(0, 4) == 0)
            begin
                add_text(CHAR_EQ, 1'b0);
                add_tok($urandom_range(0, 2));
            end
            add_ws($urandom_range(1, 2));
            if ($urandom_range(0, 9) < 7)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    add_tok($urandom_range(1, 3));
                    // now and then overrun the held-whitespace store
                    add_ws(($urandom_range(0, 4) == 0) ? $urandom_range(14, 18)
                                                       : $urandom_range(0, 3));
                end
            end
            if ($urandom_range(0, 9) != 0)
            begin
                add_text(CHAR_EQ, 1'b0);
                add_ws($urandom_range(0, 2));
                repeat ($urandom_range(1, 3))
                begin
                    add_tok($urandom_range(1, 4));
                    add_ws($urandom_range(0, 3));
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    add_ws(1);
                    add_text(CHAR_PCT, 1'b0);
                    add_tok($urandom_range(0, 3));
                    add_ws($urandom_range(0, 1));
                end
            end
        end
        add_text(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    // Offer one item and hold it until taken.
    task automatic send_item(input logic [7:0] c, input logic eol);
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    always @(posedge clk)
    begin : check_out
        token_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (want_q.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d char %02h last %0b",
                                          m_tuser, m_tdata, m_tlast));
            else
            begin
                want = want_q.pop_front();
                if (m_tuser != want.kind)
                    report_mismatch($sformatf("field kind %0d, want %0d", m_tuser, want.kind));
                if (m_tdata != want.ch)
                    report_mismatch($sformatf("char %02h, want %02h", m_tdata, want.ch));
                if (m_tlast != want.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t row;
        int       kept;
        clear_line();
        dir_tab = '{
            '{8'h00,      1'b1, BY_TABLE, 1'b1, KIND_END,   CHAR_NUL},  // empty line
            '{CHAR_HASH,  1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{8'h41,      1'b1, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{CHAR_SPACE, 1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{8'h00,      1'b0, BY_TABLE, 1'b1, KIND_NAME,  8'h00},
            '{CHAR_EQ,    1'b0, BY_MODEL, 1'b0, KIND_NAME,  CHAR_NUL},  // '=' kept in name
            '{CHAR_TAB,   1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{8'hFF,      1'b0, BY_TABLE, 1'b1, KIND_QUAL,  8'hFF},
            '{CHAR_SPACE, 1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{"k",        1'b0, BY_MODEL, 1'b0, KIND_NAME,  CHAR_NUL},
            '{CHAR_SPACE, 1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{CHAR_EQ,    1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},  // held space dropped
            '{CHAR_TAB,   1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{"v",        1'b0, BY_TABLE, 1'b1, KIND_VALUE, "v"},
            '{CHAR_TAB,   1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{"w",        1'b0, BY_MODEL, 1'b0, KIND_NAME,  CHAR_NUL},  // collapsed space
            '{CHAR_SPACE, 1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{CHAR_PCT,   1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{"z",        1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},  // line finished
            '{8'hFF,      1'b1, BY_TABLE, 1'b1, KIND_END,   CHAR_NUL},
            '{CHAR_SLASH, 1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{8'h00,      1'b1, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{CHAR_PCT,   1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{CHAR_SPACE, 1'b1, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{"n",        1'b0, BY_TABLE, 1'b1, KIND_NAME,  "n"},
            '{CHAR_SPACE, 1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{"q",        1'b0, BY_TABLE, 1'b1, KIND_QUAL,  "q"},
            '{CHAR_TAB,   1'b0, BY_TABLE, 1'b0, KIND_NAME,  CHAR_NUL},
            '{CHAR_SPACE, 1'b1, BY_MODEL, 1'b0, KIND_NAME,  CHAR_NUL}   // flush at line end
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            row = dir_tab[i];
            send_item(row.ch, row.eol);
            tokenize(row.ch, row.eol);
            if (row.by_table == BY_TABLE)
            begin
                if (row.one_res)
                    queue_want('{kind: row.kind, ch: row.res_ch, last: 1'b1});
            end
            else
                foreach (step_out[j])
                    queue_want(step_out[j]);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin src_gap_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_gap_pct = 74; snk_stall_pct = 0;  end
                2:       begin src_gap_pct = 0;  snk_stall_pct = 74; end
                default: begin src_gap_pct = 16; snk_stall_pct = 16; end
            endcase
            kept = 0;
            while (kept < PHASE_ITEMS)
            begin
                gen_line();
                foreach (line_q[i])
                begin
                    send_item(line_q[i].ch, line_q[i].eol);
                    tokenize(line_q[i].ch, line_q[i].eol);
                    foreach (step_out[j])
                        queue_want(step_out[j]);
                    if (!step_skipped)
                        kept++;
                end
            end
        end
        s_tvalid <= 1'b0;

        while (want_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
